// ===== hdl/rc_differential_drive_mixer_defines.svh =====
// Assertion macros shared by the mixer RTL.
// Needs a clk_i and an rst_ni in the scope where the macros are used.
`ifndef RC_DIFFERENTIAL_DRIVE_MIXER_DEFINES_SVH
`define RC_DIFFERENTIAL_DRIVE_MIXER_DEFINES_SVH

`ifndef SYNTHESIS
// Checked on every rising edge outside reset.
`define RCDM_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
// Checked on every rising edge, reset included.
`define RCDM_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) prop) else $error(msg);
`else
`define RCDM_ASSERT(label, prop, msg)
`define RCDM_ASSERT_ALWAYS(label, prop, msg)
`endif

`endif

// ===== hdl/rcdm_pkg.sv =====
// Types, constants and helper functions of the differential drive mixer.
// Used by the channel interfaces and all mixer modules; depends on nothing.
package rcdm_pkg;

  localparam int unsigned WidthW = 12;
  localparam int unsigned DutyW  = 8;
  localparam int unsigned SpeedW = 12;  // signed mapped speed, |value| <= 1323
  localparam int unsigned MixW   = 13;  // signed sum of two mapped speeds
  localparam int unsigned MagW   = 20;  // |(w - 1500) * max_speed| < 2**20

  localparam logic [WidthW-1:0] CenterUs   = 12'd1500;
  localparam logic [WidthW-1:0] DeadLowUs  = 12'd1450;
  localparam logic [WidthW-1:0] DeadHighUs = 12'd1550;
  localparam logic [WidthW-1:0] ModeLowUs  = 12'd1200;
  localparam logic [WidthW-1:0] ModeHighUs = 12'd1800;

  // Division by the 500 us span as a multiply by ceil(2**29 / 500) and a shift.
  // The rounding error 88 times the largest magnitude stays below 2**29, so the
  // quotient is exact for every magnitude that can occur.
  localparam int unsigned RecipShift = 29;
  localparam logic [20:0] SpanRecip  = 21'd1073742;

  localparam logic [DutyW-1:0] MaxSpeedReset = 8'd255;

  typedef enum logic [1:0] {
    MODE_DRIVE   = 2'd0,
    MODE_ARM_ONE = 2'd1,
    MODE_ARM_TWO = 2'd2,
    MODE_SCIENCE = 2'd3
  } rcdm_mode_e;

  typedef struct packed {
    logic [WidthW-1:0] steer_width;
    logic [WidthW-1:0] throttle_width;
    logic [WidthW-1:0] spin_width;
    logic [WidthW-1:0] mode_width;
    logic [WidthW-1:0] aux_width;
  } rcdm_req_t;

  typedef struct packed {
    logic [1:0]       drive_mode;
    logic [DutyW-1:0] right_fwd_pwm;
    logic [DutyW-1:0] right_rev_pwm;
    logic [DutyW-1:0] left_fwd_pwm;
    logic [DutyW-1:0] left_rev_pwm;
  } rcdm_res_t;

  // Decisions taken from the raw widths, carried along the pipeline.
  typedef struct packed {
    rcdm_mode_e mode;
    logic       spin_center;  // spin inside the dead band
    logic       spin_pos;     // spin above center
    logic       thr_pos;      // throttle above center
    logic       thr_neg;      // throttle below center
  } rcdm_ctl_t;

  function automatic logic [DutyW-1:0] clamp_speed(input logic signed [MixW-1:0] x,
                                                   input logic [DutyW-1:0] max_speed);
    logic signed [MixW-1:0] lim;
    lim = signed'({{(MixW-DutyW){1'b0}}, max_speed});
    if (x < 0) begin
      return '0;
    end else if (x > lim) begin
      return max_speed;
    end else begin
      return x[DutyW-1:0];
    end
  endfunction

endpackage

// ===== hdl/rcdm_channels.sv =====
// Valid/ready channel interfaces of the differential drive mixer.
// Depends on rcdm_pkg for the payload types.
interface rcdm_req_if;
  import rcdm_pkg::*;
  logic      valid;
  logic      ready;
  rcdm_req_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface rcdm_res_if;
  import rcdm_pkg::*;
  logic      valid;
  logic      ready;
  rcdm_res_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface rcdm_cfg_if;
  import rcdm_pkg::*;
  logic             valid;
  logic             ready;
  logic [DutyW-1:0] data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== hdl/rcdm_scale.sv =====
// Two-stage channel scaler: ((w - 1500) * max_speed) / 500, toward zero.
// Depends on rcdm_pkg for widths and the reciprocal constant.
module rcdm_scale (
  input  logic                                clk_i,
  input  logic                                ld_prod_i,
  input  logic                                ld_quot_i,
  input  logic [rcdm_pkg::WidthW-1:0]         width_i,
  input  logic [rcdm_pkg::DutyW-1:0]          max_speed_i,
  output logic signed [rcdm_pkg::SpeedW-1:0]  speed_o
);
  import rcdm_pkg::*;

  logic signed [WidthW:0]          diff;
  logic signed [WidthW+DutyW+1:0]  prod;
  logic [WidthW+DutyW+1:0]         prod_abs;
  logic [MagW-1:0]                 mag_d, mag_q;
  logic                            neg_d, neg_q;
  logic [MagW+20:0]                quot_full;
  logic [SpeedW-2:0]               quot;
  logic signed [SpeedW-1:0]        speed_d, speed_q;

  // Stage one: signed offset from center times the full-scale speed.
  always_comb begin
    diff     = signed'({1'b0, width_i}) - signed'({1'b0, CenterUs});
    prod     = diff * signed'({1'b0, max_speed_i});
    prod_abs = (prod < 0) ? unsigned'(-prod) : unsigned'(prod);
    mag_d    = prod_abs[MagW-1:0];
    neg_d    = prod < 0;
  end

  always_ff @(posedge clk_i) begin
    if (ld_prod_i) begin
      mag_q <= mag_d;
      neg_q <= neg_d;
    end
  end

  // Stage two: unsigned quotient by reciprocal, then the sign goes back on.
  always_comb begin
    quot_full = (MagW+21)'(mag_q) * (MagW+21)'(SpanRecip);
    quot      = quot_full[RecipShift +: (SpeedW-1)];
    speed_d   = neg_q ? -signed'({1'b0, quot}) : signed'({1'b0, quot});
  end

  always_ff @(posedge clk_i) begin
    if (ld_quot_i) begin
      speed_q <= speed_d;
    end
  end

  assign speed_o = speed_q;

endmodule

// ===== hdl/rcdm_mix.sv =====
// Arcade mixer: turns mapped speeds and mode decisions into H-bridge duties.
// Depends on rcdm_pkg for the control struct, result type and clamp function.
module rcdm_mix (
  input  rcdm_pkg::rcdm_ctl_t                ctl_i,
  input  logic signed [rcdm_pkg::SpeedW-1:0] steer_i,
  input  logic signed [rcdm_pkg::SpeedW-1:0] throttle_i,
  input  logic signed [rcdm_pkg::SpeedW-1:0] spin_i,
  input  logic [rcdm_pkg::DutyW-1:0]         max_speed_i,
  output rcdm_pkg::rcdm_res_t                res_o
);
  import rcdm_pkg::*;

  logic signed [MixW-1:0] ms, mt, mp;

  always_comb begin
    ms = MixW'(steer_i);
    mt = MixW'(throttle_i);
    mp = MixW'(spin_i);

    res_o            = '0;
    res_o.drive_mode = ctl_i.mode;

    if (ctl_i.mode == MODE_DRIVE) begin
      if (ctl_i.spin_center) begin
        if (ctl_i.thr_pos) begin
          res_o.right_fwd_pwm = clamp_speed(mt - ms, max_speed_i);
          res_o.left_fwd_pwm  = clamp_speed(mt + ms, max_speed_i);
        end else if (ctl_i.thr_neg) begin
          res_o.right_rev_pwm = clamp_speed(-mt - ms, max_speed_i);
          res_o.left_rev_pwm  = clamp_speed(-mt + ms, max_speed_i);
        end
      end else if (ctl_i.spin_pos) begin
        res_o.right_rev_pwm = clamp_speed(mp, max_speed_i);
        res_o.left_fwd_pwm  = clamp_speed(mp, max_speed_i);
      end else begin
        res_o.right_fwd_pwm = clamp_speed(-mp, max_speed_i);
        res_o.left_rev_pwm  = clamp_speed(-mp, max_speed_i);
      end
    end
  end

endmodule

// ===== hdl/rc_differential_drive_mixer.sv =====
// Top level of the RC differential drive mixer.
// Depends on rcdm_pkg, the channel interfaces, rcdm_scale, rcdm_mix and the
// assertion macros in rc_differential_drive_mixer_defines.svh.
//
//   Channel    Port       Direction  Carries
//   --------   --------   ---------  ----------------------------------------
//   request    in_req_i   sink       five RC pulse widths, 12 bits each
//   result     res_o      source     drive mode and four H-bridge duties
//   config     cfg_i      sink       max_speed write data, 8 bits
//
// The offset multiply, the reciprocal multiply for the divide by 500, and the
// mix and clamp each end in a register between acceptance and a valid result.
// One request is accepted every cycle until a stalled result fills every stage.
// A stalled result holds only the output register; the earlier stages keep
// filling until they are full, so ready falls only when all three are occupied.
// Reset sets max_speed to 255 and empties the pipeline; no clearing pass.
`include "rc_differential_drive_mixer_defines.svh"

module rc_differential_drive_mixer (
  input  logic       clk_i,
  input  logic       rst_ni,
  rcdm_req_if.sink   in_req_i,
  rcdm_res_if.source res_o,
  rcdm_cfg_if.sink   cfg_i
);
  import rcdm_pkg::*;

  // The full-scale speed. Write it only while the pipeline is empty (the block
  // does not enforce this), so every stage may read it directly.
  logic [DutyW-1:0] max_speed_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_speed_q <= MaxSpeedReset;
    end else if (cfg_i.valid && cfg_i.ready) begin
      max_speed_q <= cfg_i.data;
    end
  end

  assign cfg_i.ready = 1'b1;

  // Stage occupancy and the backward ready chain. A stage takes new data
  // whenever it is empty or its contents move on in the same cycle.
  logic v1_q, v2_q, v3_q;
  logic r1, r2, r3;

  assign r3 = !v3_q || res_o.ready;
  assign r2 = !v2_q || r3;
  assign r1 = !v1_q || r2;
  assign in_req_i.ready = r1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (r1) v1_q <= in_req_i.valid;
      if (r2) v2_q <= v1_q;
      if (r3) v3_q <= v2_q;
    end
  end

  // Mode decode, dead band and throttle direction come straight from the
  // widths and travel beside the arithmetic.
  rcdm_ctl_t ctl_d, ctl1_q, ctl2_q;
  rcdm_req_t req;

  always_comb begin
    req = in_req_i.data;
    if (req.mode_width < ModeLowUs) begin
      ctl_d.mode = MODE_DRIVE;
    end else if (req.mode_width > ModeHighUs) begin
      ctl_d.mode = MODE_SCIENCE;
    end else if (req.aux_width > CenterUs) begin
      ctl_d.mode = MODE_ARM_ONE;
    end else begin
      ctl_d.mode = MODE_ARM_TWO;
    end
    ctl_d.spin_center = (req.spin_width < DeadHighUs) && (req.spin_width > DeadLowUs);
    ctl_d.spin_pos    = req.spin_width > CenterUs;
    ctl_d.thr_pos     = req.throttle_width > CenterUs;
    ctl_d.thr_neg     = req.throttle_width < CenterUs;
  end

  always_ff @(posedge clk_i) begin
    if (r1) ctl1_q <= ctl_d;
    if (r2) ctl2_q <= ctl1_q;
  end

  // One scaler per channel that the mix uses.
  logic signed [SpeedW-1:0] steer_spd, thr_spd, spin_spd;

  rcdm_scale u_scale_steer (
    .clk_i       (clk_i),
    .ld_prod_i   (r1),
    .ld_quot_i   (r2),
    .width_i     (req.steer_width),
    .max_speed_i (max_speed_q),
    .speed_o     (steer_spd)
  );

  rcdm_scale u_scale_thr (
    .clk_i       (clk_i),
    .ld_prod_i   (r1),
    .ld_quot_i   (r2),
    .width_i     (req.throttle_width),
    .max_speed_i (max_speed_q),
    .speed_o     (thr_spd)
  );

  rcdm_scale u_scale_spin (
    .clk_i       (clk_i),
    .ld_prod_i   (r1),
    .ld_quot_i   (r2),
    .width_i     (req.spin_width),
    .max_speed_i (max_speed_q),
    .speed_o     (spin_spd)
  );

  // Mix and clamp, then the output register.
  rcdm_res_t res_d, res_q;

  rcdm_mix u_mix (
    .ctl_i       (ctl2_q),
    .steer_i     (steer_spd),
    .throttle_i  (thr_spd),
    .spin_i      (spin_spd),
    .max_speed_i (max_speed_q),
    .res_o       (res_d)
  );

  always_ff @(posedge clk_i) begin
    if (r3) res_q <= res_d;
  end

  assign res_o.valid = v3_q;
  assign res_o.data  = res_q;

  // On each side of the bridge at most one pin is driven.
  `RCDM_ASSERT(a_one_pin_per_side, v3_q |-> ((res_q.right_fwd_pwm == '0) || (res_q.right_rev_pwm == '0)) && ((res_q.left_fwd_pwm == '0) || (res_q.left_rev_pwm == '0)), "both pins of one side driven")
  // Arm and science modes never move the wheels.
  `RCDM_ASSERT(a_idle_outside_drive, v3_q && (res_q.drive_mode != MODE_DRIVE) |-> (res_q.right_fwd_pwm == '0) && (res_q.right_rev_pwm == '0) && (res_q.left_fwd_pwm == '0) && (res_q.left_rev_pwm == '0), "duty outside drive mode")
  // No duty exceeds the configured full scale.
  `RCDM_ASSERT(a_duty_clamped, v3_q |-> (res_q.right_fwd_pwm <= max_speed_q) && (res_q.right_rev_pwm <= max_speed_q) && (res_q.left_fwd_pwm <= max_speed_q) && (res_q.left_rev_pwm <= max_speed_q), "duty above max_speed")
  // A middle stage that cannot move on keeps its item.
  `RCDM_ASSERT(a_stage_two_held, v2_q && !r3 |=> v2_q, "stage two lost an item")
  // The request side is held off only when every stage is occupied.
  `RCDM_ASSERT_ALWAYS(a_ready_only_when_full, !in_req_i.ready |-> v1_q && v2_q && v3_q, "ready low with a free stage")

endmodule

// ===== test/rc_differential_drive_mixer_checker.sv =====
// Scoreboard for the RC differential drive mixer: predicts the drive mode and
// H-bridge duties of every accepted request and compares them with the results.
// Depends on rcdm_pkg for the payload types, the mode enum and the constants.
module rc_differential_drive_mixer_checker
  import rcdm_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             req_valid_i,
  input  logic             req_ready_i,
  input  rcdm_req_t        req_data_i,
  input  logic             res_valid_i,
  input  logic             res_ready_i,
  input  rcdm_res_t        res_data_i,
  input  logic             cfg_valid_i,
  input  logic             cfg_ready_i,
  input  logic [DutyW-1:0] cfg_data_i,
  output int               mismatch_count_o,
  output int               outstanding_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SpanUs = 500;

  logic [DutyW-1:0] max_speed_q;
  rcdm_res_t        expected_duties[$];
  rcdm_res_t        oldest;
  int               mismatches = 0;

  // Signed speed of one stick, truncated toward zero like the integer divide.
  function automatic int scale_width(logic [WidthW-1:0] w, logic [DutyW-1:0] speed);
    return ((int'(w) - int'(CenterUs)) * int'(speed)) / SpanUs;
  endfunction

  function automatic logic [DutyW-1:0] limit_duty(int x, logic [DutyW-1:0] speed);
    if (x < 0) return '0;
    if (x > int'(speed)) return speed;
    return x[DutyW-1:0];
  endfunction

  function automatic rcdm_res_t mix_duties(rcdm_req_t r, logic [DutyW-1:0] speed);
    rcdm_res_t d;
    int        steer_s;
    int        thr_s;
    int        spin_s;
    d       = '0;
    steer_s = scale_width(r.steer_width, speed);
    thr_s   = scale_width(r.throttle_width, speed);
    spin_s  = scale_width(r.spin_width, speed);
    if (r.mode_width < ModeLowUs) begin
      d.drive_mode = MODE_DRIVE;
    end else if (r.mode_width > ModeHighUs) begin
      d.drive_mode = MODE_SCIENCE;
    end else if (r.aux_width > CenterUs) begin
      d.drive_mode = MODE_ARM_ONE;
    end else begin
      d.drive_mode = MODE_ARM_TWO;
    end
    if (d.drive_mode == MODE_DRIVE) begin
      if (r.spin_width > DeadLowUs && r.spin_width < DeadHighUs) begin
        if (r.throttle_width > CenterUs) begin
          d.right_fwd_pwm = limit_duty(thr_s - steer_s, speed);
          d.left_fwd_pwm  = limit_duty(thr_s + steer_s, speed);
        end else if (r.throttle_width < CenterUs) begin
          d.right_rev_pwm = limit_duty(-thr_s - steer_s, speed);
          d.left_rev_pwm  = limit_duty(-thr_s + steer_s, speed);
        end
      end else if (r.spin_width > CenterUs) begin
        d.right_rev_pwm = limit_duty(spin_s, speed);
        d.left_fwd_pwm  = limit_duty(spin_s, speed);
      end else begin
        d.right_fwd_pwm = limit_duty(-spin_s, speed);
        d.left_rev_pwm  = limit_duty(-spin_s, speed);
      end
    end
    return d;
  endfunction

  task automatic check_field(input string name, input logic [DutyW-1:0] want,
                             input logic [DutyW-1:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_speed_q <= MaxSpeedReset;
      expected_duties.delete();
      outstanding_o    <= 0;
      mismatch_count_o <= mismatches;
    end else begin
      if (res_valid_i && res_ready_i) begin
        if (expected_duties.size() == 0) begin
          $error("result accepted with no request outstanding");
          mismatches++;
        end else begin
          oldest = expected_duties.pop_front();
          check_field("drive_mode", oldest.drive_mode, res_data_i.drive_mode);
          check_field("right_fwd_pwm", oldest.right_fwd_pwm, res_data_i.right_fwd_pwm);
          check_field("right_rev_pwm", oldest.right_rev_pwm, res_data_i.right_rev_pwm);
          check_field("left_fwd_pwm", oldest.left_fwd_pwm, res_data_i.left_fwd_pwm);
          check_field("left_rev_pwm", oldest.left_rev_pwm, res_data_i.left_rev_pwm);
        end
      end
      if (req_valid_i && req_ready_i) begin
        expected_duties.push_back(mix_duties(req_data_i, max_speed_q));
      end
      if (cfg_valid_i && cfg_ready_i) begin
        max_speed_q <= cfg_data_i;
      end
      outstanding_o    <= expected_duties.size();
      mismatch_count_o <= mismatches;
    end
  end

endmodule

// ===== test/rc_differential_drive_mixer_tb.sv =====
// Top of the RC differential drive mixer testbench: clock, reset, stimulus,
// result stalls, watchdog and verdict. Depends on rcdm_pkg, the channel
// interfaces, the mixer RTL and rc_differential_drive_mixer_checker.
module rc_differential_drive_mixer_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import rcdm_pkg::*;

  localparam int ClkHalf       = 5;
  localparam int ResetCycles   = 7;
  localparam int MaxGap        = 17;
  // The long hold-off on the result side, long enough that the three pipeline
  // stages fill up and the block drops its request ready.
  localparam int HoldOffCycles = 120;
  // Cycles without any handshake before the run is declared hung. The slowest
  // correct run idles at most the hold-off above, so this is generous.
  localparam int StallLimit    = 2000;
  // Idle cycles after the last result, before the verdict.
  localparam int DrainCycles   = 10;
  localparam int NumPhases     = 8;
  localparam int PhaseItems    = 210;

  logic clk_i;
  logic rst_ni;
  int   mismatch_count;
  int   outstanding;
  int   stuck_cycles;

  // Shared between the request and result processes: gap_free turns off the
  // random idling on both sides, hold_off_req asks the result side for one long
  // stall.
  bit gap_free     = 1'b0;
  bit hold_off_req = 1'b0;

  rcdm_req_if req_ch ();
  rcdm_res_if res_ch ();
  rcdm_cfg_if cfg_ch ();

  rc_differential_drive_mixer dut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .in_req_i (req_ch),
    .res_o    (res_ch),
    .cfg_i    (cfg_ch)
  );

  rc_differential_drive_mixer_checker duty_checker (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .req_valid_i      (req_ch.valid),
    .req_ready_i      (req_ch.ready),
    .req_data_i       (req_ch.data),
    .res_valid_i      (res_ch.valid),
    .res_ready_i      (res_ch.ready),
    .res_data_i       (res_ch.data),
    .cfg_valid_i      (cfg_ch.valid),
    .cfg_ready_i      (cfg_ch.ready),
    .cfg_data_i       (cfg_ch.data),
    .mismatch_count_o (mismatch_count),
    .outstanding_o    (outstanding)
  );

  initial begin
    clk_i = 1'b0;
    forever #ClkHalf clk_i = ~clk_i;
  end

  // The watchdog restarts its count on every handshake of any channel, so it
  // only fires when the block has stopped moving altogether.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      stuck_cycles <= 0;
    end else if ((req_ch.valid && req_ch.ready) || (res_ch.valid && res_ch.ready) ||
                 (cfg_ch.valid && cfg_ch.ready)) begin
      stuck_cycles <= 0;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
      if (stuck_cycles >= StallLimit) begin
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  // Result side. Before each result it draws a stall; while ready is low the
  // block keeps taking requests until its pipeline is full.
  initial begin : result_sink
    int stall;
    res_ch.ready <= 1'b0;
    @(posedge clk_i);
    while (!rst_ni) @(posedge clk_i);
    forever begin
      if (hold_off_req) begin
        stall        = HoldOffCycles;
        hold_off_req = 1'b0;
      end else if (gap_free) begin
        stall = 0;
      end else begin
        stall = $urandom_range(0, MaxGap);
      end
      // Ready is only lowered when a stall is due, so a ready that stays high
      // never gets two assignments in one time step.
      if (stall > 0) begin
        res_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      res_ch.ready <= 1'b1;
      @(posedge clk_i);
      while (!res_ch.valid) @(posedge clk_i);
    end
  end

  // Offers one request after a random gap and returns at the edge where it is
  // accepted. Valid stays high when the next request follows without a gap.
  task automatic offer(input rcdm_req_t r);
    int gap;
    gap = gap_free ? 0 : $urandom_range(0, MaxGap);
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    req_ch.valid <= 1'b1;
    req_ch.data  <= r;
    @(posedge clk_i);
    while (!req_ch.ready) @(posedge clk_i);
  endtask

  task automatic send_widths(input logic [WidthW-1:0] steer, input logic [WidthW-1:0] thr,
                             input logic [WidthW-1:0] spin, input logic [WidthW-1:0] mode,
                             input logic [WidthW-1:0] aux);
    rcdm_req_t r;
    r.steer_width    = steer;
    r.throttle_width = thr;
    r.spin_width     = spin;
    r.mode_width     = mode;
    r.aux_width      = aux;
    offer(r);
  endtask

  // Stops offering and waits until every request has produced its result. The
  // outstanding count is registered, so it is trusted only after the next edge.
  task automatic await_idle();
    req_ch.valid <= 1'b0;
    @(posedge clk_i);
    while (outstanding != 0) @(posedge clk_i);
  endtask

  // max_speed only changes while nothing is in flight, so every prediction is
  // made with the value the block actually uses.
  task automatic write_max_speed(input logic [DutyW-1:0] speed);
    await_idle();
    cfg_ch.valid <= 1'b1;
    cfg_ch.data  <= speed;
    @(posedge clk_i);
    while (!cfg_ch.ready) @(posedge clk_i);
    cfg_ch.valid <= 1'b0;
  endtask

  // Stick positions cluster around the usual 900..2100 us travel, with the
  // exact center, the dead band and the whole 12-bit range mixed in.
  function automatic logic [WidthW-1:0] stick_width();
    int pick;
    pick = $urandom_range(0, 19);
    if (pick == 0) return CenterUs;
    if (pick == 1) return WidthW'($urandom_range(0, 4095));
    if (pick < 5) return WidthW'($urandom_range(1440, 1560));
    return WidthW'($urandom_range(900, 2100));
  endfunction

  // Most requests are in drive mode with spin centered, where the arcade mix
  // does its work; the rest spin in place, pick another mode, or are noise.
  function automatic rcdm_req_t random_request();
    rcdm_req_t r;
    int        kind;
    kind             = $urandom_range(0, 99);
    r.steer_width    = stick_width();
    r.throttle_width = stick_width();
    r.aux_width      = stick_width();
    r.spin_width     = WidthW'($urandom_range(DeadLowUs + 1, DeadHighUs - 1));
    r.mode_width     = WidthW'($urandom_range(0, ModeLowUs - 1));
    if (kind < 55) begin
      // Keep the drive mix request as drawn.
    end else if (kind < 75) begin
      if ($urandom_range(0, 1) == 1) begin
        r.spin_width = WidthW'($urandom_range(DeadHighUs, 2100));
      end else begin
        r.spin_width = WidthW'($urandom_range(900, DeadLowUs));
      end
    end else if (kind < 90) begin
      r.mode_width = WidthW'($urandom_range(ModeLowUs, 4095));
    end else begin
      r.steer_width    = WidthW'($urandom_range(0, 4095));
      r.throttle_width = WidthW'($urandom_range(0, 4095));
      r.spin_width     = WidthW'($urandom_range(0, 4095));
      r.mode_width     = WidthW'($urandom_range(0, 4095));
      r.aux_width      = WidthW'($urandom_range(0, 4095));
    end
    return r;
  endfunction

  initial begin : stimulus
    logic [DutyW-1:0] speed;
    rst_ni       <= 1'b0;
    req_ch.valid <= 1'b0;
    req_ch.data  <= '0;
    cfg_ch.valid <= 1'b0;
    cfg_ch.data  <= '0;
    repeat (ResetCycles) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed requests at full scale: steer, throttle, spin, mode, aux.
    write_max_speed(8'd255);
    // Centered steer with throttle forward and backward uses the plain mix.
    send_widths(12'd1500, 12'd2000, 12'd1500, 12'd1000, 12'd1500);
    send_widths(12'd1500, 12'd1000, 12'd1500, 12'd1000, 12'd1500);
    // Throttle exactly centered gives no drive, whatever the steer says.
    send_widths(12'd1800, 12'd1500, 12'd1500, 12'd1000, 12'd1500);
    // Forward and backward, steering both ways.
    send_widths(12'd1800, 12'd1800, 12'd1500, 12'd1000, 12'd1500);
    send_widths(12'd1200, 12'd1800, 12'd1500, 12'd1000, 12'd1500);
    send_widths(12'd1800, 12'd1200, 12'd1500, 12'd1000, 12'd1500);
    send_widths(12'd1200, 12'd1200, 12'd1500, 12'd1000, 12'd1500);
    // Spin on and just inside the edges of its dead band.
    send_widths(12'd1600, 12'd1800, 12'd1550, 12'd1000, 12'd1500);
    send_widths(12'd1600, 12'd1800, 12'd1450, 12'd1000, 12'd1500);
    send_widths(12'd1600, 12'd1700, 12'd1549, 12'd1000, 12'd1500);
    send_widths(12'd1400, 12'd1300, 12'd1451, 12'd1000, 12'd1500);
    // Full spin in place both ways.
    send_widths(12'd1500, 12'd1500, 12'd2000, 12'd1000, 12'd1500);
    send_widths(12'd1500, 12'd1500, 12'd1000, 12'd1000, 12'd1500);
    // Field extremes; the clamp must hold every duty within max_speed.
    send_widths(12'd0, 12'd0, 12'd0, 12'd0, 12'd0);
    send_widths(12'd4095, 12'd4095, 12'd4095, 12'd4095, 12'd4095);
    send_widths(12'd4095, 12'd4095, 12'd1500, 12'd0, 12'd0);
    send_widths(12'd0, 12'd4095, 12'd1500, 12'd1199, 12'd4095);
    send_widths(12'd4095, 12'd0, 12'd1500, 12'd0, 12'd4095);
    // Mode decode at its thresholds, aux deciding between the two arm modes.
    send_widths(12'd1800, 12'd1800, 12'd1500, 12'd1200, 12'd1501);
    send_widths(12'd1800, 12'd1800, 12'd1500, 12'd1800, 12'd1500);
    send_widths(12'd1800, 12'd1800, 12'd1500, 12'd1801, 12'd4095);
    send_widths(12'd1800, 12'd1800, 12'd1500, 12'd1500, 12'd0);
    // Zero max_speed silences every duty; a speed of one truncates to zero
    // just off center.
    write_max_speed(8'd0);
    send_widths(12'd1700, 12'd2000, 12'd1500, 12'd1000, 12'd1500);
    send_widths(12'd1500, 12'd1500, 12'd4095, 12'd1000, 12'd1500);
    write_max_speed(8'd1);
    send_widths(12'd1500, 12'd1501, 12'd1500, 12'd1000, 12'd1500);

    // Random phases, each with its own max_speed. Every phase begins with the
    // request side paused until all results are in.
    for (int phase = 0; phase < NumPhases; phase++) begin
      case (phase)
        0:       speed = 8'd255;
        1:       speed = 8'd0;
        2:       speed = 8'd1;
        3:       speed = 8'd128;
        4:       speed = DutyW'($urandom_range(2, 254));
        5:       speed = 8'd255;
        6:       speed = DutyW'($urandom_range(1, 254));
        default: speed = 8'd254;
      endcase
      write_max_speed(speed);
      for (int i = 0; i < PhaseItems; i++) begin
        // Odd phases open with back-to-back traffic. In phase two the result
        // side holds off once while requests keep coming without gaps, so
        // the pipeline fills and the request ready drops.
        gap_free = ((phase % 2 == 1) && (i < 40)) || ((phase == 2) && (i >= 100) && (i < 130));
        if (phase == 2 && i == 100) hold_off_req = 1'b1;
        offer(random_request());
      end
      gap_free = 1'b0;
    end

    await_idle();
    repeat (DrainCycles) @(posedge clk_i);
    if (mismatch_count == 0 && outstanding == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
